>>> sv/spp_pkg.sv
// Shared constants and types for the starfield point projector.
// Fixed-point constants, CORDIC arctangent table, command and register codes.
// No dependencies.
package spp_pkg;

    localparam int IDX_W   = 10;
    localparam int FD_W    = 24;
    localparam int RND_W   = 16;
    localparam int CFG_W   = 24;
    localparam int WIN_W   = 12;
    localparam int POS_W   = 25;
    localparam int EXT_W   = 17;
    localparam int HALF_BW = 9;
    localparam int Q_W     = 22;
    localparam int CS_W    = 20;
    localparam int ANG_W   = 20;

    localparam int DIV_LAT    = 27;
    localparam int CORDIC_LAT = 25;
    localparam int CORDIC_N   = 16;
    localparam int MOD_STEPS  = 6;

    localparam logic [15:0]        TAN35_Q16      = 16'd45889;
    localparam logic [HALF_BW-1:0] HALF_W         = 9'd400;
    localparam logic [HALF_BW-1:0] HALF_H         = 9'd300;
    localparam logic [18:0]        TWO_PI_Q16     = 19'd411775;
    localparam logic [18:0]        PI_Q16         = 19'd205887;
    localparam logic [18:0]        HALF_PI_Q16    = 19'd102944;
    localparam logic [16:0]        CORDIC_K_Q16   = 17'd39797;
    localparam logic [2:0]         DEPTH_MIN_FRAC = 3'd7;
    localparam logic [21:0]        OFS_LIMIT      = 22'd1048576;

    localparam logic [16:0] ATAN_Q16 [CORDIC_N] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2
    };

    typedef enum logic {
        CMD_RESPAWN = 1'b0,
        CMD_UPDATE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_SPREAD        = 2'd0,
        CFG_STAR_SPEED    = 2'd1,
        CFG_WINDOW_WIDTH  = 2'd2,
        CFG_WINDOW_HEIGHT = 2'd3
    } t_cfg_reg;

endpackage

>>> sv/spp_div.sv
// Pipelined perspective divide: trunc((p*half*65536 + half*d)/d) - half, d = tan35*z,
// clamped to +-2^20. Restoring division, one quotient bit per stage. Uses spp_pkg.
module spp_div (
    input  logic                                 i_clk,
    input  logic signed [spp_pkg::POS_W-1:0]     i_pos,
    input  logic        [spp_pkg::POS_W-1:0]     i_depth,
    input  logic        [spp_pkg::HALF_BW-1:0]   i_half,
    output logic signed [spp_pkg::Q_W-1:0]       o_q
);
    localparam int D_W   = 41;
    localparam int SUM_W = 43;
    localparam int NUM_W = 52;
    localparam int STEPS = 21;
    localparam int SH_W  = D_W + STEPS;
    localparam int V_W   = 24;
    localparam int Q_W   = spp_pkg::Q_W;
    localparam logic signed [V_W-1:0] LIM = signed'(V_W'(spp_pkg::OFS_LIMIT));

    logic        [D_W-1:0]   r_d1, r_d2, r_d3, r_d4;
    logic signed [spp_pkg::POS_W-1:0] r_p1;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [NUM_W-1:0] r_num;
    logic        [NUM_W-1:0] r_mag4;
    logic                    r_neg4;

    logic [NUM_W-1:0] r_rem  [STEPS+1];
    logic [STEPS-1:0] r_qa   [STEPS+1];
    logic [D_W-1:0]   r_da   [STEPS+1];
    logic             r_nega [STEPS+1];
    logic             r_biga [STEPS+1];

    always_ff @(posedge i_clk) begin
        r_d1   <= D_W'(i_depth) * D_W'(spp_pkg::TAN35_Q16);
        r_p1   <= i_pos;
        r_sum  <= (SUM_W'(r_p1) <<< 16) + signed'({2'b00, r_d1});
        r_d2   <= r_d1;
        r_num  <= NUM_W'(r_sum) * NUM_W'(signed'({1'b0, i_half}));
        r_d3   <= r_d2;
        r_neg4 <= r_num[NUM_W-1];
        r_mag4 <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        r_d4   <= r_d3;
        r_biga[0] <= SH_W'(r_mag4) >= (SH_W'(r_d4) << STEPS);
        r_rem[0]  <= r_mag4;
        r_qa[0]   <= '0;
        r_da[0]   <= r_d4;
        r_nega[0] <= r_neg4;
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_step
        logic [SH_W-1:0] w_sh;
        logic            w_ge;
        assign w_sh = SH_W'(r_da[j-1]) << (STEPS - j);
        assign w_ge = SH_W'(r_rem[j-1]) >= w_sh;
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_ge ? NUM_W'(SH_W'(r_rem[j-1]) - w_sh) : r_rem[j-1];
            r_qa[j]   <= {r_qa[j-1][STEPS-2:0], w_ge};
            r_da[j]   <= r_da[j-1];
            r_nega[j] <= r_nega[j-1];
            r_biga[j] <= r_biga[j-1];
        end
    end

    logic signed [V_W-1:0] w_qm, w_v;
    assign w_qm = signed'(V_W'(r_qa[STEPS]));
    assign w_v  = (r_nega[STEPS] ? -w_qm : w_qm) - signed'(V_W'(i_half));

    always_ff @(posedge i_clk) begin
        priority if (r_biga[STEPS]) begin
            o_q <= r_nega[STEPS] ? Q_W'(-LIM) : Q_W'(LIM);
        end else if (w_v > LIM) begin
            o_q <= Q_W'(LIM);
        end else if (w_v < -LIM) begin
            o_q <= Q_W'(-LIM);
        end else begin
            o_q <= Q_W'(w_v);
        end
    end

endmodule

>>> sv/spp_cordic.sv
// Pipelined range-reduced CORDIC: cos and sin (Q16) of a positive Q16 angle.
// Modulo 2*pi by conditional subtracts, fold to +-pi/2, 16 rotation stages. Uses spp_pkg.
module spp_cordic (
    input  logic                                i_clk,
    input  logic        [spp_pkg::POS_W-1:0]    i_angle,
    output logic signed [spp_pkg::CS_W-1:0]     o_cos,
    output logic signed [spp_pkg::CS_W-1:0]     o_sin
);
    localparam int MS = spp_pkg::MOD_STEPS;
    localparam int N  = spp_pkg::CORDIC_N;
    localparam int AW = spp_pkg::ANG_W;
    localparam int CW = spp_pkg::CS_W;
    localparam int PW = spp_pkg::POS_W;

    logic [PW-1:0] r_m [MS+1];
    assign r_m[0] = i_angle;

    for (genvar j = 1; j <= MS; j++) begin : g_mod
        logic [PW-1:0] w_k;
        assign w_k = PW'(spp_pkg::TWO_PI_Q16) << (MS - j);
        always_ff @(posedge i_clk) begin
            r_m[j] <= (r_m[j-1] >= w_k) ? r_m[j-1] - w_k : r_m[j-1];
        end
    end

    logic signed [AW-1:0] r_w;
    logic signed [AW-1:0] r_ca [N+1];
    logic signed [CW-1:0] r_cx [N+1];
    logic signed [CW-1:0] r_cy [N+1];
    logic                 r_cn [N+1];

    always_ff @(posedge i_clk) begin
        r_w <= (r_m[MS] > PW'(spp_pkg::PI_Q16)) ?
               signed'(AW'(r_m[MS])) - signed'(AW'(spp_pkg::TWO_PI_Q16)) :
               signed'(AW'(r_m[MS]));
        priority if (r_w > signed'(AW'(spp_pkg::HALF_PI_Q16))) begin
            r_ca[0] <= r_w - signed'(AW'(spp_pkg::PI_Q16));
            r_cn[0] <= 1'b1;
        end else if (r_w < -signed'(AW'(spp_pkg::HALF_PI_Q16))) begin
            r_ca[0] <= r_w + signed'(AW'(spp_pkg::PI_Q16));
            r_cn[0] <= 1'b1;
        end else begin
            r_ca[0] <= r_w;
            r_cn[0] <= 1'b0;
        end
        r_cx[0] <= signed'(CW'(spp_pkg::CORDIC_K_Q16));
        r_cy[0] <= '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [CW-1:0] w_dx, w_dy;
        logic signed [AW-1:0] w_at;
        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;
        assign w_at = signed'(AW'(spp_pkg::ATAN_Q16[i]));
        always_ff @(posedge i_clk) begin
            if (r_ca[i] >= 0) begin
                r_cx[i+1] <= r_cx[i] - w_dx;
                r_cy[i+1] <= r_cy[i] + w_dy;
                r_ca[i+1] <= r_ca[i] - w_at;
            end else begin
                r_cx[i+1] <= r_cx[i] + w_dx;
                r_cy[i+1] <= r_cy[i] - w_dy;
                r_ca[i+1] <= r_ca[i] + w_at;
            end
            r_cn[i+1] <= r_cn[i];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= r_cn[N] ? -r_cx[N] : r_cx[N];
        o_sin <= r_cn[N] ? -r_cy[N] : r_cy[N];
    end

endmodule

>>> sv/starfield_point_projector_top.sv
// Starfield point projector top: star table memory, respawn/update pipeline, rotation, output.
// Depends on spp_pkg, spp_div and spp_cordic.
//
// One command is taken per clock while busy is low, and every accepted command yields
// exactly one result beat, o_result_strobe high for one cycle; the receiver cannot
// stall. The star table is one memory (x, y, depth) read at start and written back at
// the last stage. busy rises only while a command for the same star index is still in
// the 33-stage pipeline, so back-to-back commands on distinct stars run at one per
// cycle and a repeat of an index waits until the earlier command has left the pipeline.
module starfield_point_projector_top #(
    parameter int NUM_STARS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_cmd,
    input  logic [spp_pkg::IDX_W-1:0]        i_star_index,
    input  logic [spp_pkg::FD_W-1:0]         i_frame_delta,
    input  logic [spp_pkg::RND_W-1:0]        i_rand_x,
    input  logic [spp_pkg::RND_W-1:0]        i_rand_y,
    input  logic [spp_pkg::RND_W-1:0]        i_rand_z,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [spp_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_result_strobe,
    output logic                             o_pixel_valid,
    output logic [spp_pkg::WIN_W-1:0]        o_pixel_x,
    output logic [spp_pkg::WIN_W-1:0]        o_pixel_y,
    output logic                             o_respawned
);
    localparam int AW     = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
    localparam int PW     = spp_pkg::POS_W;
    localparam int XW     = spp_pkg::EXT_W;
    localparam int WORD_W = 3 * PW;
    localparam int PIPE_N = spp_pkg::DIV_LAT + 4;
    localparam int LAT    = PIPE_N + 3;
    localparam int CIN    = spp_pkg::DIV_LAT - spp_pkg::CORDIC_LAT;
    localparam int PR_W   = spp_pkg::Q_W + spp_pkg::CS_W;
    localparam int SM_W   = PR_W + 1;
    localparam int PX_W   = 28;
    localparam int RP_W   = 43;
    localparam int RZ_W   = 41;

    typedef struct packed {
        logic                          valid;
        logic                          inrange;
        spp_pkg::t_cmd                 cmd;
        logic [spp_pkg::IDX_W-1:0]     idx;
        logic signed [PW-1:0]          xpos;
        logic signed [PW-1:0]          ypos;
        logic [PW-1:0]                 zpos;
        logic                          dead;
        logic signed [PW-1:0]          rsp_x;
        logic signed [PW-1:0]          rsp_y;
        logic [PW-1:0]                 rsp_z;
    } t_ctrl;

    // configuration
    logic [spp_pkg::CFG_W-1:0] r_spread, r_speed;
    logic [spp_pkg::WIN_W-1:0] r_win_w, r_win_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread <= 24'd4194304;
            r_speed  <= 24'd65536;
            r_win_w  <= 12'd800;
            r_win_h  <= 12'd600;
        end else if (i_cfg_valid) begin
            unique case (spp_pkg::t_cfg_reg'(i_cfg_index))
                spp_pkg::CFG_SPREAD:        r_spread <= i_cfg_data;
                spp_pkg::CFG_STAR_SPEED:    r_speed  <= i_cfg_data;
                spp_pkg::CFG_WINDOW_WIDTH:  r_win_w  <= i_cfg_data[spp_pkg::WIN_W-1:0];
                spp_pkg::CFG_WINDOW_HEIGHT: r_win_h  <= i_cfg_data[spp_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // star table
    logic [WORD_W-1:0] r_mem [NUM_STARS];
    logic [WORD_W-1:0] r_rd;
    logic [XW-1:0]     w_rd_ext, w_wr_ext;
    logic              w_accept;

    assign w_rd_ext = XW'(i_star_index);
    assign w_accept = i_start && !o_busy;

    // stage A
    logic                          r_a_valid, r_a_inrange;
    spp_pkg::t_cmd                 r_a_cmd;
    logic [spp_pkg::IDX_W-1:0]     r_a_idx;
    logic [spp_pkg::FD_W-1:0]      r_a_fd;
    logic [spp_pkg::RND_W-1:0]     r_a_rx, r_a_ry, r_a_rz;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_ext[AW-1:0]];
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
        r_a_inrange <= w_rd_ext < XW'(NUM_STARS);
        r_a_cmd     <= spp_pkg::t_cmd'(i_cmd);
        r_a_idx     <= i_star_index;
        r_a_fd      <= i_frame_delta;
        r_a_rx      <= i_rand_x;
        r_a_ry      <= i_rand_y;
        r_a_rz      <= i_rand_z;
    end

    // stage B: products
    logic                          r_b_valid, r_b_inrange;
    spp_pkg::t_cmd                 r_b_cmd;
    logic [spp_pkg::IDX_W-1:0]     r_b_idx;
    logic [31:0]                   r_b_dz;
    logic signed [RP_W-1:0]        r_b_pxp, r_b_pyp;
    logic [RZ_W-1:0]               r_b_pz;
    logic [WORD_W-1:0]             r_b_word;
    logic signed [17:0]            w_a_fx, w_a_fy;
    logic [47:0]                   w_a_dz;

    assign w_a_fx = signed'({1'b0, r_a_rx, 1'b0}) - 18'sd65536;
    assign w_a_fy = signed'({1'b0, r_a_ry, 1'b0}) - 18'sd65536;
    assign w_a_dz = 48'(r_a_fd) * 48'(r_speed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_inrange <= r_a_inrange;
        r_b_cmd     <= r_a_cmd;
        r_b_idx     <= r_a_idx;
        r_b_dz      <= w_a_dz[47:16];
        r_b_pxp     <= RP_W'(w_a_fx) * RP_W'(signed'({1'b0, r_spread}));
        r_b_pyp     <= RP_W'(w_a_fy) * RP_W'(signed'({1'b0, r_spread}));
        r_b_pz      <= RZ_W'(RZ_W'(r_a_rz) + RZ_W'(spp_pkg::DEPTH_MIN_FRAC)) * RZ_W'(r_spread);
        r_b_word    <= r_rd;
    end

    // stage B combinational: depth update and respawn values
    logic signed [33:0]   w_z;
    logic signed [RP_W-1:0] w_tx, w_ty;
    logic [PW-1:0]        w_rz;
    t_ctrl                w_ctrl_b;

    assign w_z  = 34'(signed'(r_b_word[PW-1:0])) - signed'({2'b00, r_b_dz});
    assign w_tx = (r_b_pxp + (r_b_pxp < 0 ? RP_W'(65535) : RP_W'(0))) >>> 16;
    assign w_ty = (r_b_pyp + (r_b_pyp < 0 ? RP_W'(65535) : RP_W'(0))) >>> 16;
    assign w_rz = r_b_pz[RZ_W-1] ? {1'b0, {(PW-1){1'b1}}} : {1'b0, r_b_pz[RZ_W-2:16]};

    always_comb begin
        w_ctrl_b.valid   = r_b_valid;
        w_ctrl_b.inrange = r_b_inrange;
        w_ctrl_b.cmd     = r_b_cmd;
        w_ctrl_b.idx     = r_b_idx;
        w_ctrl_b.xpos    = signed'(r_b_word[3*PW-1:2*PW]);
        w_ctrl_b.ypos    = signed'(r_b_word[2*PW-1:PW]);
        w_ctrl_b.zpos    = w_z[PW-1:0];
        w_ctrl_b.dead    = w_z[33] || (w_z == '0);
        w_ctrl_b.rsp_x   = PW'(w_tx);
        w_ctrl_b.rsp_y   = PW'(w_ty);
        w_ctrl_b.rsp_z   = w_rz;
    end

    // control pipeline alongside divider, CORDIC and rotation
    t_ctrl r_pipe [PIPE_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe[0].valid <= 1'b0;
        end else begin
            r_pipe[0] <= w_ctrl_b;
        end
    end

    for (genvar j = 1; j < PIPE_N; j++) begin : g_pipe
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[j].valid <= 1'b0;
            end else begin
                r_pipe[j] <= r_pipe[j-1];
            end
        end
    end

    logic signed [spp_pkg::Q_W-1:0]  w_qx, w_qy;
    logic signed [spp_pkg::CS_W-1:0] w_c, w_s;

    spp_div u_div_x (
        .i_clk   (i_clk),
        .i_pos   (r_pipe[0].xpos),
        .i_depth (r_pipe[0].zpos),
        .i_half  (spp_pkg::HALF_W),
        .o_q     (w_qx)
    );

    spp_div u_div_y (
        .i_clk   (i_clk),
        .i_pos   (r_pipe[0].ypos),
        .i_depth (r_pipe[0].zpos),
        .i_half  (spp_pkg::HALF_H),
        .o_q     (w_qy)
    );

    spp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_angle (r_pipe[CIN].zpos),
        .o_cos   (w_c),
        .o_sin   (w_s)
    );

    // rotation about the centre
    logic signed [PR_W-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [SM_W-1:0] r_sx, r_sy;
    logic signed [SM_W-1:0] w_tpx, w_tpy;
    logic signed [PX_W-1:0] r_px, r_py;

    assign w_tpx = (r_sx + (r_sx < 0 ? SM_W'(65535) : SM_W'(0))) >>> 16;
    assign w_tpy = (r_sy + (r_sy < 0 ? SM_W'(65535) : SM_W'(0))) >>> 16;

    always_ff @(posedge i_clk) begin
        r_xc <= PR_W'(w_qx) * PR_W'(w_c);
        r_ys <= PR_W'(w_qy) * PR_W'(w_s);
        r_xs <= PR_W'(w_qx) * PR_W'(w_s);
        r_yc <= PR_W'(w_qy) * PR_W'(w_c);
        r_sx <= SM_W'(r_xc) - SM_W'(r_ys);
        r_sy <= SM_W'(r_xs) + SM_W'(r_yc);
        r_px <= PX_W'(w_tpx) + signed'(PX_W'(spp_pkg::HALF_W));
        r_py <= PX_W'(w_tpy) + signed'(PX_W'(spp_pkg::HALF_H));
    end

    // final decision, write-back and result beat
    t_ctrl w_last;
    logic  w_off, w_rsp;

    assign w_last   = r_pipe[PIPE_N-1];
    assign w_wr_ext = XW'(w_last.idx);
    assign w_off    = (r_px < 0) || (r_px >= signed'(PX_W'(r_win_w))) ||
                      (r_py < 0) || (r_py >= signed'(PX_W'(r_win_h)));
    assign w_rsp    = (w_last.cmd == spp_pkg::CMD_RESPAWN) || w_last.dead || w_off;

    always_ff @(posedge i_clk) begin
        if (w_last.valid && w_last.inrange) begin
            r_mem[w_wr_ext[AW-1:0]] <= w_rsp ?
                {w_last.rsp_x, w_last.rsp_y, w_last.rsp_z} :
                {w_last.xpos, w_last.ypos, w_last.zpos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
            o_pixel_valid   <= 1'b0;
            o_respawned     <= 1'b0;
        end else begin
            o_result_strobe <= w_last.valid;
            o_pixel_valid   <= w_last.valid && w_last.inrange && !w_rsp;
            o_respawned     <= w_last.valid && w_last.inrange && w_rsp;
        end
        o_pixel_x <= (w_last.inrange && !w_rsp) ? r_px[spp_pkg::WIN_W-1:0] : '0;
        o_pixel_y <= (w_last.inrange && !w_rsp) ? r_py[spp_pkg::WIN_W-1:0] : '0;
    end

    // interlock on a star index still in flight
    logic [PIPE_N-1:0] w_hit;

    for (genvar j = 0; j < PIPE_N; j++) begin : g_hit
        assign w_hit[j] = r_pipe[j].valid && (r_pipe[j].idx == i_star_index);
    end

    assign o_busy = (|w_hit) ||
                    (r_a_valid && (r_a_idx == i_star_index)) ||
                    (r_b_valid && (r_b_idx == i_star_index));

    // checks
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_result_strobe)
        else $error("accepted command produced no result beat");

    a_excl_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !(o_pixel_valid && o_respawned))
        else $error("pixel and respawn flagged together");

    a_flag_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid || o_respawned) |-> o_result_strobe)
        else $error("result flag outside a result beat");

    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pipe[0].valid && w_accept) |-> (r_pipe[0].idx != i_star_index))
        else $error("same star accepted while in flight");

endmodule
